[rtl/segment_tree_range_sum_defines.svh]
// Assertion macros for the segment tree range sum block.
`ifndef SEGMENT_TREE_RANGE_SUM_DEFINES_SVH
`define SEGMENT_TREE_RANGE_SUM_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment tree assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment tree assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/stsum_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package stsum_pkg;

  localparam int DEFAULT_LEAVES      = 1024;
  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int CMD_W               = 2;
  localparam int POS_W               = 10;
  localparam int SUM_W               = 32;

  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_LEAF_RD,
    OP_LEAF_WR,
    OP_SIB_RD,
    OP_UP_WR,
    OP_Q_RD,
    OP_Q_ACC,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             pos_bad;
    logic             range_empty;
    logic             l_gt_r;
    logic             at_root;
    logic             clear_done;
    logic             out_free;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/stsum_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module stsum_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  stsum_pkg::dp_status_t status,
  output stsum_pkg::dp_cmd_t    cmd
);
  import stsum_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_LEAF_RD  = 4'd3;
  localparam logic [3:0] S_LEAF_WR  = 4'd4;
  localparam logic [3:0] S_SIB_RD   = 4'd5;
  localparam logic [3:0] S_UP_WR    = 4'd6;
  localparam logic [3:0] S_Q_RD     = 4'd7;
  localparam logic [3:0] S_Q_ACC    = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.command)
          CMD_QUERY: state_next = status.range_empty ? S_DONE : S_Q_RD;
          CMD_SET, CMD_ADD: state_next = status.pos_bad ? S_DONE : S_LEAF_RD;
          default: state_next = S_DONE;
        endcase
      end
      S_LEAF_RD: begin
        cmd.op     = OP_LEAF_RD;
        state_next = S_LEAF_WR;
      end
      S_LEAF_WR: begin
        cmd.op     = OP_LEAF_WR;
        state_next = S_SIB_RD;
      end
      S_SIB_RD: begin
        if (status.at_root) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_SIB_RD;
          state_next = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.op     = OP_UP_WR;
        state_next = S_SIB_RD;
      end
      S_Q_RD: begin
        if (status.l_gt_r) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_Q_RD;
          state_next = S_Q_ACC;
        end
      end
      S_Q_ACC: begin
        cmd.op     = OP_Q_ACC;
        state_next = S_Q_RD;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/stsum_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module stsum_dp #(
  parameter int LEAVES      = stsum_pkg::DEFAULT_LEAVES,
  parameter int VALUE_WIDTH = stsum_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  stsum_pkg::dp_cmd_t                  cmd,
  output stsum_pkg::dp_status_t               status,
  input  logic        [stsum_pkg::CMD_W-1:0]  command,
  input  logic        [stsum_pkg::POS_W-1:0]  first_pos,
  input  logic        [stsum_pkg::POS_W-1:0]  last_pos,
  input  logic signed [stsum_pkg::SUM_W-1:0]  value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [stsum_pkg::SUM_W-1:0]  sum
);
  import stsum_pkg::*;

  localparam int LG    = $clog2(LEAVES);
  localparam int P     = 2 ** LG;
  localparam int AW    = LG + 1;
  localparam int NODES = 2 * P;
  localparam int CW    = ((AW > POS_W) ? AW : POS_W) + 1;

  logic [VALUE_WIDTH-1:0] mem [NODES];

  logic [CMD_W-1:0]       cmd_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [VALUE_WIDTH-1:0] acc;
  logic [AW:0]            l;
  logic [AW-1:0]          r;
  logic                   ta;
  logic                   tb;
  logic                   pos_bad;
  logic                   range_empty;
  logic [AW-1:0]          clr_addr;
  logic [VALUE_WIDTH-1:0] rd_a;
  logic [VALUE_WIDTH-1:0] rd_b;

  logic                   we;
  logic [AW-1:0]          wa;
  logic [VALUE_WIDTH-1:0] wd;
  logic                   rea;
  logic [AW-1:0]          ra;
  logic                   reb;
  logic [AW-1:0]          rb;
  logic [VALUE_WIDTH-1:0] leaf_new;
  logic [VALUE_WIDTH-1:0] up_sum;
  logic                   first_bad;
  logic                   last_over;

  assign first_bad = CW'(first_pos) >= CW'(LEAVES);
  assign last_over = CW'(last_pos) >= CW'(P);
  assign leaf_new  = (cmd_q == CMD_SET) ? val_q : rd_a + val_q;
  assign up_sum    = acc + rd_a;

  assign status.command     = cmd_q;
  assign status.pos_bad     = pos_bad;
  assign status.range_empty = range_empty;
  assign status.l_gt_r      = l > {1'b0, r};
  assign status.at_root     = (l == (AW + 1)'(1));
  assign status.clear_done  = (clr_addr == AW'(NODES - 1));
  assign status.out_free    = !rsp_valid || !rsp_stall;

  always_comb begin
    we  = 1'b0;
    wa  = l[AW-1:0];
    wd  = val_q;
    rea = 1'b0;
    ra  = l[AW-1:0];
    reb = 1'b0;
    rb  = r;
    unique case (cmd.op)
      OP_CLEAR: begin
        we = 1'b1;
        wa = clr_addr;
        wd = '0;
      end
      OP_LEAF_RD: rea = 1'b1;
      OP_LEAF_WR: begin
        we = 1'b1;
        wd = leaf_new;
      end
      OP_SIB_RD: begin
        rea = 1'b1;
        ra  = l[AW-1:0] ^ AW'(1);
      end
      OP_UP_WR: begin
        we = 1'b1;
        wa = l[AW:1];
        wd = up_sum;
      end
      OP_Q_RD: begin
        rea = 1'b1;
        reb = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rea) begin
      rd_a <= mem[ra];
    end
    if (reb) begin
      rd_b <= mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.op == OP_OUT_LOAD) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        cmd_q       <= command;
        val_q       <= VALUE_WIDTH'(value);
        acc         <= '0;
        l           <= (AW + 1)'(P) + (AW + 1)'(first_pos);
        r           <= last_over ? AW'(NODES - 1) : AW'(P) + AW'(last_pos);
        pos_bad     <= first_bad;
        range_empty <= first_bad || (first_pos > last_pos);
      end
      OP_LEAF_WR: acc <= leaf_new;
      OP_UP_WR: begin
        acc <= up_sum;
        l   <= l >> 1;
      end
      OP_Q_RD: begin
        ta <= l[0];
        tb <= !r[0];
        l  <= (l + (AW + 1)'(l[0])) >> 1;
        r  <= (r - AW'(!r[0])) >> 1;
      end
      OP_Q_ACC: acc <= acc + (ta ? rd_a : '0) + (tb ? rd_b : '0);
      OP_OUT_LOAD: sum <= (cmd_q == CMD_QUERY) ? SUM_W'(acc) : '0;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/segment_tree_range_sum.sv]
// Requests are taken one at a time: req_stall holds off a new request until the last is done;
// each tree level costs a node-memory read then an add.
// Updates walk leaf to root, a sibling read then a parent write per level; queries walk
// both bounds upward.
// Reset: synchronous, active high; a clearing pass zeroes the node memory while requests
// are stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_tree_range_sum_defines.svh"
module segment_tree_range_sum #(
  parameter int LEAVES      = stsum_pkg::DEFAULT_LEAVES,
  parameter int VALUE_WIDTH = stsum_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic        [stsum_pkg::CMD_W-1:0]  command,
  input  logic        [stsum_pkg::POS_W-1:0]  first_pos,
  input  logic        [stsum_pkg::POS_W-1:0]  last_pos,
  input  logic signed [stsum_pkg::SUM_W-1:0]  value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [stsum_pkg::SUM_W-1:0]  sum
);
  import stsum_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  stsum_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  stsum_dp #(
    .LEAVES      (LEAVES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .command   (command),
    .first_pos (first_pos),
    .last_pos  (last_pos),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sum       (sum)
  );

  `ASSERT_NEXT(a_busy_after_req, clk, rst, req_valid && !req_stall, req_stall)
  `ASSERT_IMPL(a_stall_while_clear, clk, rst, cmd.op == OP_CLEAR, req_stall)
  `ASSERT_IMPL(a_load_on_accept, clk, rst, cmd.op == OP_LOAD, req_valid && !req_stall)
  `ASSERT_IMPL(a_out_load_free, clk, rst, cmd.op == OP_OUT_LOAD, !rsp_valid || !rsp_stall)

endmodule
`default_nettype wire
